>>> hdl/slew_rate_limiter_macros.svh
// Assertion helpers shared by the slew limiter RTL.
// Both macros expect a clock named clk in scope; SRL_ASSERT also expects a reset named rst.
`ifndef SLEW_RATE_LIMITER_MACROS_SVH
`define SLEW_RATE_LIMITER_MACROS_SVH

// Checked only outside reset.
`define SRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Types and constants shared by the slew limiter modules.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int SAMPLE_W = 32;
  localparam int STEP_W   = 25;
  localparam int VOICE_W  = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [STEP_W-1:0]          step_t;
  typedef logic [VOICE_W-1:0]         voice_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_UP   = 2'd0,
    CFG_STEP_DOWN = 2'd1,
    CFG_LEGATO    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // 0.5 in Q8.24; gate counts as high strictly above it
  localparam sample_t GATE_HALF = 32'sh0080_0000;

  localparam step_t STEP_RESET = 25'd761;

endpackage

>>> hdl/srl_mem.sv
// ----------------------------------------------------------------------------
// srl_mem
// Per-voice last-output store: one synchronous read port, one write port,
// per-entry valid bits so unwritten voices read as zero, and a bypass for a
// read that lands on the entry being written in the same cycle.
// ----------------------------------------------------------------------------
module srl_mem #(
  parameter int VOICES = 16,
  parameter int AW     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  srl_pkg::sample_t      wr_data,
  output srl_pkg::sample_t      rd_value
);
  import srl_pkg::*;

  sample_t            mem [VOICES];
  logic [VOICES-1:0]  vld;
  sample_t            rd_data;
  logic               rd_vld;
  logic               byp;
  sample_t            byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      byp    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
        byp    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (byp) begin
      rd_value = byp_data;
    end else if (rd_vld) begin
      rd_value = rd_data;
    end else begin
      rd_value = '0;
    end
  end

endmodule

>>> hdl/slew_rate_limiter.sv
// ----------------------------------------------------------------------------
// slew_rate_limiter
// Per-voice slew limiter for Q8.24 control-voltage samples.
// ----------------------------------------------------------------------------
// Takes one item per clock unless sample_stall is high and returns one result
// per item: the read stage reads the voice's last output from a synchronous
// memory, the next stage limits the move toward the new sample, writes it
// back and loads the output register. Back-to-back items on the same voice
// are forwarded around the memory, so throughput stays at one item per
// cycle as long as results are taken. In legato mode every item uses voice 0
// and the output jumps to the input unless the gate was above 0.5 on the
// previous legato item. Voice indexes at or above VOICES wrap modulo VOICES.
// Configuration may be written only while no item is in flight.
// ----------------------------------------------------------------------------
`include "slew_rate_limiter_macros.svh"

module slew_rate_limiter #(
  parameter int VOICES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [srl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  srl_pkg::step_t               cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  srl_pkg::voice_t              voice,
  input  srl_pkg::sample_t             sample_in,
  input  srl_pkg::sample_t             gate_in,
  output logic                         result_valid,
  input  logic                         result_stall,
  output srl_pkg::voice_t              voice_out,
  output srl_pkg::sample_t             sample_out
);
  import srl_pkg::*;

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef logic [15:0][AW-1:0] vmap_t;

  // voice -> voice modulo VOICES, built at elaboration
  function automatic vmap_t build_vmap();
    vmap_t m;
    int    r;
    r = 0;
    for (int i = 0; i < 16; i++) begin
      m[i] = AW'(r);
      r = (r == VOICES - 1) ? 0 : r + 1;
    end
    return m;
  endfunction

  localparam vmap_t VMAP = build_vmap();

  // configuration
  step_t step_up;
  step_t step_down;
  logic  legato_mode;
  logic  note_held;

  // read stage
  logic          s1_valid;
  logic [AW-1:0] s1_voice;
  sample_t       s1_sample;
  logic          s1_gate_hi;

  logic          accept;
  logic          s1_adv;
  logic [AW-1:0] rd_addr;
  sample_t       prev;

  logic signed [SAMPLE_W:0] prev33;
  logic signed [SAMPLE_W:0] x33;
  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] up33;
  logic signed [SAMPLE_W:0] dn33;
  logic signed [SAMPLE_W:0] slew33;
  logic                     jump;
  sample_t                  result;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_up     <= STEP_RESET;
      step_down   <= STEP_RESET;
      legato_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_UP:   step_up     <= cfg_data;
        CFG_STEP_DOWN: step_down   <= cfg_data;
        CFG_LEGATO:    legato_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s1_adv       = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !s1_adv;
  assign accept       = sample_valid && !sample_stall;
  assign rd_addr      = legato_mode ? '0 : VMAP[voice];

  srl_mem #(
    .VOICES (VOICES),
    .AW     (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .wr_en    (s1_adv),
    .wr_addr  (s1_voice),
    .wr_data  (result),
    .rd_value (prev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_voice   <= rd_addr;
      s1_sample  <= sample_in;
      s1_gate_hi <= (gate_in > GATE_HALF);
    end
  end

  // difference formed one bit wider so it never wraps
  always_comb begin
    prev33 = {prev[SAMPLE_W-1], prev};
    x33    = {s1_sample[SAMPLE_W-1], s1_sample};
    diff   = x33 - prev33;
    up33   = {{(SAMPLE_W + 1 - STEP_W){1'b0}}, step_up};
    dn33   = {{(SAMPLE_W + 1 - STEP_W){1'b0}}, step_down};
    if (diff > 0 && diff > up33) begin
      slew33 = prev33 + up33;
    end else if (diff <= 0 && diff < -dn33) begin
      slew33 = prev33 - dn33;
    end else begin
      slew33 = x33;
    end
    jump   = legato_mode && !note_held;
    result = jump ? s1_sample : sample_t'(slew33[SAMPLE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_held <= 1'b0;
    end else if (s1_adv && legato_mode) begin
      note_held <= s1_gate_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      voice_out  <= VOICE_W'(s1_voice);
      sample_out <= result;
    end
  end

  `SRL_ASSERT(a_rise_limited, s1_adv && !jump && diff > 0 |-> (slew33 - prev33) <= up33, "rise exceeds step_up")
  `SRL_ASSERT(a_fall_limited, s1_adv && !jump && diff <= 0 |-> (prev33 - slew33) <= dn33, "fall exceeds step_down")
  `SRL_ASSERT(a_result_from_stage, $rose(result_valid) |-> $past(s1_adv), "result without a finished item")
  `SRL_ASSERT(a_legato_voice0, s1_adv && legato_mode |=> voice_out == '0, "legato result not on voice 0")
  `SRL_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !s1_valid && !result_valid, "pipeline not empty after reset")

endmodule
